>>> rtl/brfds_pkg.sv
// ----------------------------------------------------------------------------
// brfds_pkg
// Shared widths, codes and controller/datapath types for the byte ring FIFO.
// ----------------------------------------------------------------------------
package brfds_pkg;

   localparam int MODE_W      = 2;
   localparam int BYTE_W      = 8;
   localparam int COUNT_W     = 11;
   localparam int STATUS_W    = 2;
   localparam int VALUE_W     = 11;
   localparam int FILL_W      = 11;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int DLEN_W      = 4;
   localparam int DELIM_MAX   = 8;
   localparam int DELIM_IDX_W = 3;

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD    = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_DELETE = 2'd2,
      MODE_SEARCH = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK     = 2'd0,
      STS_REJECT = 2'd1,
      STS_EMPTY  = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN = 2'd0,
      CSR_LENGTH  = 2'd1
   } csr_idx_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_SEARCH
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_ADD,
      CMD_REMOVE_IMM,
      CMD_DELETE,
      CMD_SEARCH_IMM,
      CMD_POP_START,
      CMD_POP_STEP,
      CMD_SEARCH_START,
      CMD_SEARCH_STEP,
      CMD_SEARCH_DONE
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic slot_free;
      logic fill_zero;
      logic pop_zero;
      logic search_trivial;
      logic pop_last;
      logic search_hit;
      logic search_end;
   } dp_status_type;

endpackage

>>> rtl/brfds_ifs.sv
// ----------------------------------------------------------------------------
// brfds channel interfaces
// Request, response and register write channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface brfds_req_if;
   import brfds_pkg::*;

   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [BYTE_W-1:0]   data_in;
   logic [COUNT_W-1:0]  count;
   logic                run_first;

   modport source (output valid, mode, data_in, count, run_first, input ready);
   modport sink   (input valid, mode, data_in, count, run_first, output ready);
endinterface

interface brfds_rsp_if;
   import brfds_pkg::*;

   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   data_out;
   logic                last;
   logic [STATUS_W-1:0] status;
   logic [VALUE_W-1:0]  result_value;
   logic [FILL_W-1:0]   fill_level;

   modport source (output valid, data_out, last, status, result_value, fill_level,
                   input ready);
   modport sink   (input valid, data_out, last, status, result_value, fill_level,
                   output ready);
endinterface

interface brfds_csr_if;
   import brfds_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/brfds_ctrl.sv
// ----------------------------------------------------------------------------
// brfds_ctrl
// Sequencer: decodes requests, runs multi-cycle pop and delimiter scan.
// ----------------------------------------------------------------------------
module brfds_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  brfds_pkg::mode_type     req_mode,
   output logic                    req_ready,
   input  brfds_pkg::dp_status_type sts,
   output brfds_pkg::dp_cmd_type   cmd
);
   import brfds_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd.op    = CMD_NONE;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = sts.slot_free;
            if (req_valid && sts.slot_free) begin
               unique case (req_mode)
                  MODE_ADD:    cmd.op = CMD_ADD;
                  MODE_REMOVE: begin
                     if (sts.fill_zero || sts.pop_zero) begin
                        cmd.op = CMD_REMOVE_IMM;
                     end else begin
                        cmd.op   = CMD_POP_START;
                        state_in = S_POP;
                     end
                  end
                  MODE_DELETE: cmd.op = CMD_DELETE;
                  MODE_SEARCH: begin
                     if (sts.search_trivial) begin
                        cmd.op = CMD_SEARCH_IMM;
                     end else begin
                        cmd.op   = CMD_SEARCH_START;
                        state_in = S_SEARCH;
                     end
                  end
               endcase
            end
         end
         S_POP: begin
            if (sts.slot_free) begin
               cmd.op = CMD_POP_STEP;
               if (sts.pop_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_SEARCH: begin
            if (sts.search_hit || sts.search_end) begin
               if (sts.slot_free) begin
                  cmd.op   = CMD_SEARCH_DONE;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.op = CMD_SEARCH_STEP;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

>>> rtl/brfds_dp.sv
// ----------------------------------------------------------------------------
// brfds_dp
// Byte store, ring pointers, delimiter window and response register.
// ----------------------------------------------------------------------------
module brfds_dp #(
   parameter int DEPTH   = 1024,
   parameter int MAX_POP = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  brfds_pkg::dp_cmd_type             cmd,
   output brfds_pkg::dp_status_type          sts,
   input  logic [brfds_pkg::BYTE_W-1:0]      req_data_in,
   input  logic [brfds_pkg::COUNT_W-1:0]     req_count,
   input  logic                              req_run_first,
   input  logic                              csr_valid,
   input  logic [brfds_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [brfds_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [brfds_pkg::BYTE_W-1:0]      rsp_data_out,
   output logic                              rsp_last,
   output logic [brfds_pkg::STATUS_W-1:0]    rsp_status,
   output logic [brfds_pkg::VALUE_W-1:0]     rsp_result_value,
   output logic [brfds_pkg::FILL_W-1:0]      rsp_fill_level
);
   import brfds_pkg::*;

   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PTR_W = AW + 1;
   localparam int WW    = (PTR_W > COUNT_W) ? PTR_W : COUNT_W;
   localparam int POP_W = (MAX_POP > 1) ? $clog2(MAX_POP + 1) : 1;

   logic [BYTE_W-1:0]                  mem_ff [DEPTH];
   logic [BYTE_W-1:0]                  rdata_ff;
   logic [PTR_W-1:0]                   rp_ff, rp_in;
   logic [PTR_W-1:0]                   wp_ff, wp_in;
   logic                               rej_ff, rej_in;
   logic [DELIM_MAX-1:0][BYTE_W-1:0]   pat_ff;
   logic [DLEN_W-1:0]                  dlen_ff;
   logic [PTR_W-1:0]                   scan_ff, scan_in;
   logic [PTR_W-1:0]                   cnt_ff, cnt_in;
   logic [POP_W-1:0]                   pop_n_ff, pop_n_in;
   logic [DELIM_MAX-1:0][BYTE_W-1:0]   win_ff, win_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]                  data_ff, data_in;
   logic                               last_ff, last_in;
   status_type                         status_ff, status_in;
   logic [VALUE_W-1:0]                 value_ff, value_in;
   logic [FILL_W-1:0]                  fill_ff, fill_in;
   logic                               load;

   logic [PTR_W-1:0]                   fill;
   logic [PTR_W-1:0]                   free;
   logic                               fill_full;
   logic                               rej_nx;
   logic                               drop;
   logic [PTR_W-1:0]                   del_n;
   logic [WW-1:0]                      pop_cap;
   logic [POP_W-1:0]                   pop_calc;
   logic [DLEN_W-1:0]                  eff_len;
   logic [PTR_W-1:0]                   nbytes;
   logic                               hit_bytes;
   logic                               rd_en;
   logic                               rd_start;
   logic [AW-1:0]                      rd_addr;
   logic                               slot_free;

   assign fill      = wp_ff - rp_ff;
   assign free      = PTR_W'(DEPTH) - fill;
   assign fill_full = fill[PTR_W-1];
   assign rej_nx    = req_run_first ? (WW'(req_count) > WW'(free)) : rej_ff;
   assign drop      = rej_nx || fill_full;
   assign del_n     = (WW'(req_count) < WW'(fill)) ? PTR_W'(req_count) : fill;
   assign pop_cap   = (WW'(req_count) > WW'(MAX_POP)) ? WW'(MAX_POP) : WW'(req_count);
   assign pop_calc  = (pop_cap < WW'(fill)) ? POP_W'(pop_cap) : POP_W'(fill);
   assign eff_len   = (dlen_ff > DLEN_W'(DELIM_MAX)) ? DLEN_W'(DELIM_MAX) : dlen_ff;
   assign nbytes    = cnt_ff + PTR_W'(1);
   assign win_in    = {win_ff[DELIM_MAX-2:0], rdata_ff};
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      logic [DELIM_IDX_W-1:0] pat_idx;
      hit_bytes = 1'b1;
      for (int j = 0; j < DELIM_MAX; j++) begin
         pat_idx = DELIM_IDX_W'(eff_len - DLEN_W'(1) - DLEN_W'(j));
         if ((DLEN_W'(j) < eff_len) && (win_in[j] != pat_ff[pat_idx])) begin
            hit_bytes = 1'b0;
         end
      end
   end

   always_comb begin
      sts.slot_free      = slot_free;
      sts.fill_zero      = (fill == '0);
      sts.pop_zero       = (pop_calc == '0);
      sts.search_trivial = (eff_len == '0) || (WW'(eff_len) > WW'(fill));
      sts.pop_last       = (WW'(cnt_ff) + WW'(1)) == WW'(pop_n_ff);
      sts.search_hit     = hit_bytes && (eff_len != '0) && (WW'(nbytes) >= WW'(eff_len));
      sts.search_end     = (nbytes == fill);
   end

   // pointer, counter and read sequencing
   always_comb begin
      rp_in    = rp_ff;
      wp_in    = wp_ff;
      rej_in   = rej_ff;
      scan_in  = scan_ff;
      cnt_in   = cnt_ff;
      pop_n_in = pop_n_ff;
      rd_en    = 1'b0;
      rd_start = 1'b0;
      unique case (cmd.op)
         CMD_ADD: begin
            rej_in = rej_nx;
            if (!drop) begin
               wp_in = wp_ff + PTR_W'(1);
            end
         end
         CMD_DELETE: rp_in = rp_ff + del_n;
         CMD_POP_START, CMD_SEARCH_START: begin
            rd_en    = 1'b1;
            rd_start = 1'b1;
            cnt_in   = '0;
            pop_n_in = pop_calc;
         end
         CMD_POP_STEP: begin
            cnt_in = cnt_ff + PTR_W'(1);
            if (sts.pop_last) begin
               rp_in = rp_ff + PTR_W'(pop_n_ff);
            end else begin
               rd_en = 1'b1;
            end
         end
         CMD_SEARCH_STEP: begin
            rd_en  = 1'b1;
            cnt_in = cnt_ff + PTR_W'(1);
         end
         default: ;
      endcase
      rd_addr = rd_start ? rp_ff[AW-1:0] : scan_ff[AW-1:0];
      if (rd_en) begin
         scan_in = (rd_start ? rp_ff : scan_ff) + PTR_W'(1);
      end
   end

   // response payload
   always_comb begin
      load      = 1'b1;
      data_in   = '0;
      last_in   = 1'b1;
      status_in = STS_OK;
      value_in  = '0;
      fill_in   = FILL_W'(fill);
      unique case (cmd.op)
         CMD_ADD: begin
            status_in = drop ? STS_REJECT : STS_OK;
            fill_in   = drop ? FILL_W'(fill) : FILL_W'(fill + PTR_W'(1));
         end
         CMD_REMOVE_IMM: begin
            if (fill == '0) begin
               status_in = STS_EMPTY;
            end
         end
         CMD_DELETE: begin
            value_in = VALUE_W'(del_n);
            fill_in  = FILL_W'(fill - del_n);
         end
         CMD_SEARCH_IMM: ;
         CMD_POP_STEP: begin
            data_in  = rdata_ff;
            last_in  = sts.pop_last;
            value_in = VALUE_W'(pop_n_ff);
            fill_in  = FILL_W'(fill - PTR_W'(pop_n_ff));
         end
         CMD_SEARCH_DONE: begin
            value_in = sts.search_hit ? VALUE_W'(nbytes) : '0;
         end
         default: load = 1'b0;
      endcase
      rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.op == CMD_ADD && !drop) begin
         mem_ff[wp_ff[AW-1:0]] <= req_data_in;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff        <= '0;
         wp_ff        <= '0;
         rej_ff       <= 1'b0;
         pat_ff       <= '0;
         dlen_ff      <= DLEN_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         rej_ff       <= rej_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_idx_type'(csr_index))
               CSR_PATTERN: pat_ff  <= csr_data;
               CSR_LENGTH:  dlen_ff <= csr_data[DLEN_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff  <= scan_in;
      cnt_ff   <= cnt_in;
      pop_n_ff <= pop_n_in;
      if (cmd.op == CMD_SEARCH_STEP) begin
         win_ff <= win_in;
      end
      if (load) begin
         data_ff   <= data_in;
         last_ff   <= last_in;
         status_ff <= status_in;
         value_ff  <= value_in;
         fill_ff   <= fill_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data_out     = data_ff;
   assign rsp_last         = last_ff;
   assign rsp_status       = status_ff;
   assign rsp_result_value = value_ff;
   assign rsp_fill_level   = fill_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      WW'(fill) <= WW'(DEPTH))
      else $error("fill level above store depth");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> slot_free)
      else $error("response loaded over a pending transfer");

   a_pop_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == CMD_POP_STEP) |-> (pop_n_ff != '0) && (WW'(cnt_ff) < WW'(pop_n_ff)))
      else $error("pop step outside its byte count");

   a_add_grow: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == CMD_ADD && !drop) |=> (fill == $past(fill) + PTR_W'(1)))
      else $error("stored byte did not raise fill level");

endmodule

>>> rtl/byte_ring_fifo_with_delimiter_search.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_delimiter_search
// Byte ring FIFO with record admission, pop, discard and delimiter scan.
// ----------------------------------------------------------------------------
// Channels: req_chan takes one command per transfer (add byte, remove,
// delete, search); rsp_chan returns results, last marking the final one of
// a command; csr_chan writes the delimiter pattern (index 0) and length
// (index 1), always ready; the user must make writes only while the block is
// idle, as the block itself does not enforce this. Every result sits in an
// output register and appears the cycle after it is formed. Add, delete,
// remove of nothing, and a search that cannot match run back to back. A
// remove of n bytes returns one byte per cycle while no response is held,
// off the single registered read port of the byte store. A search scans
// one byte per cycle on that port, up to the first match or the fill level.
// Reset: pointers and admission flag clear, pattern 0, length 1; the byte
// store is not cleared and no clearing pass runs.
// Stall: a held response stops pop and scan output and holds off req_chan.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_delimiter_search #(
   parameter int DEPTH   = 1024,
   parameter int MAX_POP = 64
) (
   input logic        clock,
   input logic        reset,
   brfds_req_if.sink  req_chan,
   brfds_rsp_if.source rsp_chan,
   brfds_csr_if.sink  csr_chan
);
   import brfds_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type sts;
   logic          req_ready;

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;

   brfds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (mode_type'(req_chan.mode)),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   brfds_dp #(
      .DEPTH   (DEPTH),
      .MAX_POP (MAX_POP)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_data_in      (req_chan.data_in),
      .req_count        (req_chan.count),
      .req_run_first    (req_chan.run_first),
      .csr_valid        (csr_chan.valid),
      .csr_index        (csr_chan.index),
      .csr_data         (csr_chan.data),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_data_out     (rsp_chan.data_out),
      .rsp_last         (rsp_chan.last),
      .rsp_status       (rsp_chan.status),
      .rsp_result_value (rsp_chan.result_value),
      .rsp_fill_level   (rsp_chan.fill_level)
   );

endmodule
